// ===== rtl/kreiss_oliger_grid_dissipation_top_assert.svh =====
// assertion macros for the grid dissipation block
`ifndef KREISS_OLIGER_GRID_DISSIPATION_TOP_ASSERT_SVH
`define KREISS_OLIGER_GRID_DISSIPATION_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KOGD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kogd same-cycle check failed");
// next-cycle implication
`define KOGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kogd next-cycle check failed");
`else
`define KOGD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KOGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/kogd_pkg.sv =====
// shared constants and widths of the grid dissipation block
`default_nettype none

package kogd_pkg;

  // store geometry
  localparam int GRID_MAX    = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int ADDR_W      = $clog2(GRID_MAX);

  // field widths
  localparam int REQ_W      = 2;
  localparam int SAMPLE_W   = 32;
  localparam int LEN_W      = 11;
  localparam int OP_W       = 3;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int CTR_W     = ADDR_W + 2;
  localparam int ACC_W     = SAMPLE_BITS + 5;
  localparam int MAG_W     = ACC_W - 1;
  localparam int PROD_W    = MAG_W + GAIN_W;
  localparam int RND_SHIFT = 18;
  localparam int Q_W       = PROD_W - RND_SHIFT;
  localparam int D_W       = Q_W + 1;
  localparam int V_W       = ((D_W > SAMPLE_BITS) ? D_W : SAMPLE_BITS) + 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN   = 2'd2;

  // pass selection codes
  localparam logic [OP_W-1:0] OP_INT_BND  = 3'd0;
  localparam logic [OP_W-1:0] OP_LEFT     = 3'd1;
  localparam logic [OP_W-1:0] OP_ORG_EVEN = 3'd2;
  localparam logic [OP_W-1:0] OP_ORG_ODD  = 3'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LENGTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCISION_INDEX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_GAIN    = 3'd5;

  // register reset values
  localparam logic [OP_W-1:0]   OPERATION_RST      = OP_INT_BND;
  localparam logic [LEN_W-1:0]  GRID_LENGTH_RST    = 11'd1024;
  localparam logic [ADDR_W-1:0] EXCISION_INDEX_RST = '0;
  localparam logic [GAIN_W-1:0] INTERIOR_GAIN_RST  = 16'd13107;
  localparam logic [GAIN_W-1:0] BOUNDARY_GAIN_RST  = 16'd16384;
  localparam logic [GAIN_W-1:0] ORIGIN_GAIN_RST    = 16'd14746;

  // result kinds
  localparam logic RES_READ = 1'b0;
  localparam logic RES_RUN  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/kogd_chan_if.sv =====
// request and result channel interfaces of the grid dissipation block
`default_nettype none

interface kogd_in_if;
  import kogd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [9:0]                 grid_index;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, req_type, grid_index, sample_in, input ready);
  modport sink (input valid, req_type, grid_index, sample_in, output ready);
endinterface

interface kogd_out_if;
  import kogd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       saturated;

  modport source (output valid, result_kind, sample_out, saturated, input ready);
  modport sink (input valid, result_kind, sample_out, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/kogd_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module kogd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kreiss_oliger_grid_dissipation_top.sv =====
// Grid dissipation block: sample store with an in-place fourth-difference pass.
// Requests arrive as beats on in_ch: write sample, read sample or run pass.
// A write is taken and gives no result. A read gives one beat on out_ch
// with the sample read from the store. A run gives one beat (kind run, sample
// zero, clipping flag) when the chosen pass has finished.
// Each updated grid point takes five store reads through the single read
// port, a drain of term scaling and summing, one multiply by the gain, one
// rounding step and one write-back. Runs that change nothing go straight to
// their result beat. in_ch.ready is high only while no request is in progress,
// so one request is worked on at a time. The result sits in an output
// register: a stalled out_ch still lets writes through, and holds a finished
// read or run until it is taken. Configuration is written on cfg_we with
// cfg_index and cfg_data; the user must write it only while idle, which the
// block itself does not enforce. Synchronous reset loads the default registers
// and empties the output; the store holds nothing defined until it is written.
`default_nettype none

`include "kreiss_oliger_grid_dissipation_top_assert.svh"

module kreiss_oliger_grid_dissipation_top (
  input wire logic                             clk,
  input wire logic                             rst_n,
  kogd_in_if.sink                              in_ch,
  kogd_out_if.source                           out_ch,
  input wire logic                             cfg_we,
  input wire logic [kogd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [kogd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kogd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDWAIT, ST_ISSUE, ST_DRAIN, ST_MUL, ST_RND, ST_WB, ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    PH_INT, PH_BND, PH_LEFT, PH_ORG1, PH_ORG0
  } phase_t;

  typedef enum logic [1:0] {
    COEF_ONE, COEF_FOUR, COEF_SIX
  } coef_t;

  localparam logic signed [V_W-1:0] SAT_MAX =
    {{(V_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [V_W-1:0] SAT_MIN =
    {{(V_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [2:0] LAST_TERM = 3'd4;
  localparam logic [2:0] LAST_DRAIN = 3'd1;

  // configuration registers
  logic [OP_W-1:0]   operation_r;
  logic [LEN_W-1:0]  grid_length_r;
  logic [ADDR_W-1:0] excision_index_r;
  logic [GAIN_W-1:0] interior_gain_r;
  logic [GAIN_W-1:0] boundary_gain_r;
  logic [GAIN_W-1:0] origin_gain_r;

  // sequencer state
  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] ctr_r, ctr_nxt;
  logic [ADDR_W-1:0] tgt_r, tgt_nxt;
  logic [2:0]        k_r, k_nxt;
  logic              odd_r, odd_nxt;
  logic              sat_r, sat_nxt;
  logic              resp_kind_r, resp_kind_nxt;
  logic [SAMPLE_W-1:0] resp_sample_r, resp_sample_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic              out_sat_r, out_sat_nxt;

  // store port
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // datapath
  logic                    a_vld_r, b_vld_r;
  coef_t                   a_coef_r;
  logic                    a_neg_r, b_neg_r, a_tgt_r;
  logic signed [ACC_W-1:0] term_r, acc_r;
  logic [SAMPLE_BITS-1:0]  tsamp_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    sign_r;
  logic signed [D_W-1:0]   d_r;

  logic                    in_acc, out_free;
  logic [LEN_W-1:0]        n_len, n_m2, n_m3;
  logic signed [CTR_W-1:0] iss_off, iss_abs;
  logic [ADDR_W-1:0]       iss_addr;
  coef_t                   iss_coef;
  logic                    iss_neg;
  logic signed [ACC_W-1:0] rd_ext, term_mag, acc_sum, acc_abs;
  logic [GAIN_W-1:0]       gain_sel;
  logic [PROD_W-1:0]       rnd_sum;
  logic [Q_W-1:0]          q_mag;
  logic signed [V_W-1:0]   v_raw, v_sat;
  logic                    v_clip;
  logic [SAMPLE_W-1:0]     rd_out;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r      <= OPERATION_RST;
      grid_length_r    <= GRID_LENGTH_RST;
      excision_index_r <= EXCISION_INDEX_RST;
      interior_gain_r  <= INTERIOR_GAIN_RST;
      boundary_gain_r  <= BOUNDARY_GAIN_RST;
      origin_gain_r    <= ORIGIN_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPERATION:      operation_r      <= cfg_data[OP_W-1:0];
        CFG_GRID_LENGTH:    grid_length_r    <= cfg_data[LEN_W-1:0];
        CFG_EXCISION_INDEX: excision_index_r <= cfg_data[ADDR_W-1:0];
        CFG_INTERIOR_GAIN:  interior_gain_r  <= cfg_data;
        CFG_BOUNDARY_GAIN:  boundary_gain_r  <= cfg_data;
        CFG_ORIGIN_GAIN:    origin_gain_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid length clipped to the store
  assign n_len = (grid_length_r > LEN_W'(GRID_MAX)) ? LEN_W'(GRID_MAX) : grid_length_r;
  assign n_m2  = n_len - LEN_W'(2);
  assign n_m3  = n_len - LEN_W'(3);

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // stencil term address, mirrored about the origin
  assign iss_off  = CTR_W'(ctr_r) + CTR_W'(2) - CTR_W'(k_r);
  assign iss_abs  = iss_off[CTR_W-1] ? -iss_off : iss_off;
  assign iss_addr = iss_abs[ADDR_W-1:0];

  // stencil weight of the term: 1 -4 6 -4 1, odd mirror flips the sign
  always_comb begin
    iss_coef = COEF_ONE;
    iss_neg  = 1'b0;
    case (k_r)
      3'd1, 3'd3: begin
        iss_coef = COEF_FOUR;
        iss_neg  = 1'b1;
      end
      3'd2: iss_coef = COEF_SIX;
      default: ;
    endcase
    if (odd_r && iss_off[CTR_W-1]) begin
      iss_neg = !iss_neg;
    end
  end

  // scale the sample just read
  assign rd_ext = ACC_W'($signed(ram_rdata));
  always_comb begin
    unique case (a_coef_r)
      COEF_FOUR: term_mag = rd_ext <<< 2;
      COEF_SIX:  term_mag = (rd_ext <<< 2) + (rd_ext <<< 1);
      default:   term_mag = rd_ext;
    endcase
  end

  assign acc_sum = b_neg_r ? (acc_r - term_r) : (acc_r + term_r);
  assign acc_abs = acc_r[ACC_W-1] ? -acc_r : acc_r;

  // gain of the current phase
  always_comb begin
    unique case (phase_r)
      PH_INT:           gain_sel = interior_gain_r;
      PH_BND, PH_LEFT:  gain_sel = boundary_gain_r;
      default:          gain_sel = origin_gain_r;
    endcase
  end

  // round to nearest, ties away from zero
  assign rnd_sum = prod_r + PROD_W'(2 ** (RND_SHIFT - 1));
  assign q_mag   = rnd_sum[PROD_W-1:RND_SHIFT];

  // new sample and clipping
  always_comb begin
    if (phase_r == PH_BND || phase_r == PH_LEFT) begin
      v_raw = V_W'($signed(tsamp_r)) + V_W'(d_r);
    end else begin
      v_raw = V_W'($signed(tsamp_r)) - V_W'(d_r);
    end
    v_clip = 1'b1;
    if (v_raw > SAT_MAX) begin
      v_sat = SAT_MAX;
    end else if (v_raw < SAT_MIN) begin
      v_sat = SAT_MIN;
    end else begin
      v_sat  = v_raw;
      v_clip = 1'b0;
    end
  end

  assign rd_out = SAMPLE_W'($signed(ram_rdata));

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    ctr_nxt         = ctr_r;
    tgt_nxt         = tgt_r;
    k_nxt           = k_r;
    odd_nxt         = odd_r;
    sat_nxt         = sat_r;
    resp_kind_nxt   = resp_kind_r;
    resp_sample_nxt = resp_sample_r;
    out_valid_nxt   = out_valid_r;
    out_kind_nxt    = out_kind_r;
    out_sample_nxt  = out_sample_r;
    out_sat_nxt     = out_sat_r;
    ram_we          = 1'b0;
    ram_waddr       = in_ch.grid_index[ADDR_W-1:0];
    ram_wdata       = in_ch.sample_in[SAMPLE_BITS-1:0];
    ram_re          = 1'b0;
    ram_raddr       = in_ch.grid_index[ADDR_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.req_type)
            REQ_WRITE: ram_we = 1'b1;
            REQ_READ: begin
              ram_re    = 1'b1;
              state_nxt = ST_RDWAIT;
            end
            REQ_RUN: begin
              sat_nxt         = 1'b0;
              resp_kind_nxt   = RES_RUN;
              resp_sample_nxt = '0;
              k_nxt           = '0;
              odd_nxt         = 1'b0;
              state_nxt       = ST_RESP;
              case (operation_r)
                OP_INT_BND: begin
                  if (n_len >= LEN_W'(5)) begin
                    state_nxt = ST_ISSUE;
                    if (CTR_W'(excision_index_r) + CTR_W'(5) <= CTR_W'(n_len)) begin
                      phase_nxt = PH_INT;
                      ctr_nxt   = excision_index_r + ADDR_W'(2);
                      tgt_nxt   = excision_index_r + ADDR_W'(2);
                    end else begin
                      phase_nxt = PH_BND;
                      ctr_nxt   = n_m3[ADDR_W-1:0];
                      tgt_nxt   = n_m2[ADDR_W-1:0];
                    end
                  end
                end
                OP_LEFT: begin
                  state_nxt = ST_ISSUE;
                  phase_nxt = PH_LEFT;
                  ctr_nxt   = ADDR_W'(2);
                  tgt_nxt   = ADDR_W'(1);
                end
                OP_ORG_EVEN, OP_ORG_ODD: begin
                  state_nxt = ST_ISSUE;
                  phase_nxt = PH_ORG1;
                  ctr_nxt   = ADDR_W'(1);
                  tgt_nxt   = ADDR_W'(1);
                  odd_nxt   = (operation_r == OP_ORG_ODD);
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_RDWAIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = RES_READ;
          out_sample_nxt = rd_out;
          out_sat_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          resp_kind_nxt   = RES_READ;
          resp_sample_nxt = rd_out;
          state_nxt       = ST_RESP;
        end
      end
      ST_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = iss_addr;
        if (k_r == LAST_TERM) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (k_r == LAST_DRAIN) begin
          k_nxt     = '0;
          state_nxt = ST_MUL;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_MUL: state_nxt = ST_RND;
      ST_RND: state_nxt = ST_WB;
      ST_WB: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        ram_wdata = v_sat[SAMPLE_BITS-1:0];
        if (v_clip) begin
          sat_nxt = 1'b1;
        end
        state_nxt = ST_RESP;
        unique case (phase_r)
          PH_INT: begin
            state_nxt = ST_ISSUE;
            if (CTR_W'(ctr_r) + CTR_W'(4) <= CTR_W'(n_len)) begin
              ctr_nxt = ctr_r + ADDR_W'(1);
              tgt_nxt = ctr_r + ADDR_W'(1);
            end else begin
              phase_nxt = PH_BND;
              ctr_nxt   = n_m3[ADDR_W-1:0];
              tgt_nxt   = n_m2[ADDR_W-1:0];
            end
          end
          PH_ORG1: begin
            state_nxt = ST_ISSUE;
            phase_nxt = PH_ORG0;
            ctr_nxt   = '0;
            tgt_nxt   = '0;
          end
          default: ;
        endcase
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = resp_kind_r;
          out_sample_nxt = resp_sample_r;
          out_sat_nxt    = (resp_kind_r == RES_RUN) ? sat_r : 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_INT;
      k_r         <= '0;
      odd_r       <= 1'b0;
      sat_r       <= 1'b0;
      resp_kind_r <= RES_READ;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      odd_r       <= odd_nxt;
      sat_r       <= sat_nxt;
      resp_kind_r <= resp_kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ctr_r         <= ctr_nxt;
    tgt_r         <= tgt_nxt;
    resp_sample_r <= resp_sample_nxt;
    out_kind_r    <= out_kind_nxt;
    out_sample_r  <= out_sample_nxt;
    out_sat_r     <= out_sat_nxt;
  end

  // term pipeline, accumulator, gain multiply and rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= (state_r == ST_ISSUE);
      b_vld_r <= a_vld_r;
    end
    a_coef_r <= iss_coef;
    a_neg_r  <= iss_neg;
    a_tgt_r  <= (iss_addr == tgt_r);
    b_neg_r  <= a_neg_r;
    term_r   <= term_mag;
    if (a_vld_r && a_tgt_r) begin
      tsamp_r <= ram_rdata;
    end
    if (state_r == ST_ISSUE && k_r == 3'd0) begin
      acc_r <= '0;
    end else if (b_vld_r) begin
      acc_r <= acc_sum;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(acc_abs[MAG_W-1:0]) * PROD_W'(gain_sel);
      sign_r <= acc_r[ACC_W-1];
    end
    if (state_r == ST_RND) begin
      d_r <= sign_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end
  end

  kogd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (GRID_MAX)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.sample_out  = out_sample_r;
  assign out_ch.saturated   = out_sat_r;

  // checks
  `KOGD_ASSERT_NEXT(a_run_holds_off, clk, rst_n, in_acc && in_ch.req_type == REQ_RUN, !in_ch.ready)
  `KOGD_ASSERT_IMPL(a_sat_from_wb, clk, rst_n, $rose(sat_r), $past(state_r == ST_WB))
  `KOGD_ASSERT_IMPL(a_out_load, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_RDWAIT) || $past(state_r == ST_RESP))
  `KOGD_ASSERT_IMPL(a_drained_at_mul, clk, rst_n, state_r == ST_MUL, !a_vld_r && !b_vld_r)

endmodule

`default_nettype wire
